[design/crl_pkg.sv]
// Shared types and constants for the color ramp lookup pipeline.
package crl_pkg;

  localparam int VAL_W       = 16;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 4;
  localparam int COLOR_W     = NUM_CH * CH_W;
  localparam int IDX_PORT_W  = 3;
  localparam int CNT_W       = 4;
  localparam int CNT_EXT_W   = CNT_W + 1;
  localparam int NUM_W       = VAL_W + CH_W;
  localparam int DIV_STAGES  = 4;
  localparam int DIV_STEP    = CH_W / DIV_STAGES;
  localparam int ST_IN       = 1;
  localparam int ST_ENC      = 2;
  localparam int ST_OPND     = 3;
  localparam int ST_PROD     = 4;
  localparam int ST_NUM      = 5;
  localparam int ST_DIV0     = 6;
  localparam int STAGES      = ST_DIV0 + DIV_STAGES - 1;
  localparam int TAIL_STAGES = STAGES - ST_OPND;

  localparam logic [CNT_W-1:0] STOP_COUNT_RESET = 4'd4;
  localparam logic [CNT_EXT_W-1:0] MIN_STOPS    = 5'd2;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MAP  = 1'b1
  } cmd_t;

  typedef logic [STAGES:ST_IN] stage_en_t;

endpackage

[design/crl_stop_table.sv]
// Stop storage, parallel threshold search and segment operand fetch.
module crl_stop_table #(
  parameter int MAX_STOPS = 8,
  parameter int IW        = 3
) (
  input  logic                        clk,
  input  crl_pkg::stage_en_t          le,
  input  logic                        wr_en,
  input  logic [IW-1:0]               wr_addr,
  input  logic [crl_pkg::VAL_W-1:0]   wr_pos,
  input  logic [crl_pkg::COLOR_W-1:0] wr_color,
  input  logic [crl_pkg::VAL_W-1:0]   s1_value,
  input  logic [IW-1:0]               n_last,
  output logic [IW-1:0]               s3_upper,
  output logic                        s3_mix,
  output logic [crl_pkg::VAL_W-1:0]   s3_d,
  output logic [crl_pkg::VAL_W-1:0]   s3_n,
  output logic [crl_pkg::COLOR_W-1:0] s3_cl,
  output logic [crl_pkg::COLOR_W-1:0] s3_cu
);

  logic [crl_pkg::VAL_W-1:0]   pos_r   [MAX_STOPS];
  logic [crl_pkg::COLOR_W-1:0] color_r [MAX_STOPS];

  logic [MAX_STOPS-1:0]        lt;
  logic [IW-1:0]               upper_nxt;
  logic [IW-1:0]               s2_upper_r;
  logic [crl_pkg::VAL_W-1:0]   s2_value_r;

  logic [IW-1:0]               lower;
  logic [crl_pkg::VAL_W-1:0]   tl;
  logic [crl_pkg::VAL_W-1:0]   tu;
  logic                        mix_nxt;

  logic [IW-1:0]               s3_upper_r;
  logic                        s3_mix_r;
  logic [crl_pkg::VAL_W-1:0]   s3_d_r;
  logic [crl_pkg::VAL_W-1:0]   s3_n_r;
  logic [crl_pkg::COLOR_W-1:0] s3_cl_r;
  logic [crl_pkg::COLOR_W-1:0] s3_cu_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_r[wr_addr]   <= wr_pos;
      color_r[wr_addr] <= wr_color;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_STOPS; i++) begin
      lt[i] = (s1_value < pos_r[i]);
    end
    upper_nxt = n_last;
    for (int i = MAX_STOPS - 2; i >= 0; i--) begin
      if ((IW'(i) < n_last) && lt[i]) begin
        upper_nxt = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (le[crl_pkg::ST_ENC]) begin
      s2_upper_r <= upper_nxt;
      s2_value_r <= s1_value;
    end
  end

  always_comb begin
    lower   = s2_upper_r - IW'(1);
    tl      = pos_r[lower];
    tu      = pos_r[s2_upper_r];
    mix_nxt = (s2_upper_r != '0) && (tu > tl) && (s2_value_r < tu);
  end

  always_ff @(posedge clk) begin
    if (le[crl_pkg::ST_OPND]) begin
      s3_upper_r <= s2_upper_r;
      s3_mix_r   <= mix_nxt;
      s3_d_r     <= tu - tl;
      s3_n_r     <= s2_value_r - tl;
      s3_cl_r    <= color_r[lower];
      s3_cu_r    <= color_r[s2_upper_r];
    end
  end

  assign s3_upper = s3_upper_r;
  assign s3_mix   = s3_mix_r;
  assign s3_d     = s3_d_r;
  assign s3_n     = s3_n_r;
  assign s3_cl    = s3_cl_r;
  assign s3_cu    = s3_cu_r;

endmodule

[design/crl_mix_lane.sv]
// One color channel: weighted mix and pipelined rounding division.
module crl_mix_lane (
  input  logic                      clk,
  input  crl_pkg::stage_en_t        le,
  input  logic [crl_pkg::CH_W-1:0]  cl,
  input  logic [crl_pkg::CH_W-1:0]  cu,
  input  logic [crl_pkg::VAL_W-1:0] d,
  input  logic [crl_pkg::VAL_W-1:0] n,
  input  logic                      mix,
  output logic [crl_pkg::CH_W-1:0]  res
);

  localparam int NW = crl_pkg::NUM_W;
  localparam int DS = crl_pkg::DIV_STAGES;

  logic [crl_pkg::VAL_W-1:0] dn;
  logic [NW-1:0]             p_lo_nxt;
  logic [NW-1:0]             p_hi_nxt;

  logic [NW-1:0]             p_lo_r;
  logic [NW-1:0]             p_hi_r;
  logic [crl_pkg::VAL_W-1:0] d4_r;
  logic [crl_pkg::CH_W-1:0]  cu4_r;
  logic                      mix4_r;

  logic [NW-1:0]             num5_r;
  logic [crl_pkg::VAL_W-1:0] d5_r;
  logic [crl_pkg::CH_W-1:0]  cu5_r;
  logic                      mix5_r;

  logic [NW-1:0]             rem_r  [DS];
  logic [crl_pkg::CH_W-1:0]  quo_r  [DS];
  logic [crl_pkg::VAL_W-1:0] dd_r   [DS];
  logic [crl_pkg::CH_W-1:0]  cuq_r  [DS];
  logic                      mixq_r [DS];

  logic [NW-1:0]             rem_nxt [DS];
  logic [crl_pkg::CH_W-1:0]  quo_nxt [DS];
  logic [crl_pkg::VAL_W-1:0] dd_in   [DS];
  logic [crl_pkg::CH_W-1:0]  cu_in   [DS];
  logic                      mix_in  [DS];
  logic [NW-1:0]             dsh     [DS][crl_pkg::DIV_STEP];

  always_comb begin
    dn       = d - n;
    p_lo_nxt = NW'(cl) * NW'(dn);
    p_hi_nxt = NW'(cu) * NW'(n);
  end

  always_ff @(posedge clk) begin
    if (le[crl_pkg::ST_PROD]) begin
      p_lo_r <= p_lo_nxt;
      p_hi_r <= p_hi_nxt;
      d4_r   <= d;
      cu4_r  <= cu;
      mix4_r <= mix;
    end
  end

  always_ff @(posedge clk) begin
    if (le[crl_pkg::ST_NUM]) begin
      num5_r <= p_lo_r + p_hi_r + NW'(d4_r >> 1);
      d5_r   <= d4_r;
      cu5_r  <= cu4_r;
      mix5_r <= mix4_r;
    end
  end

  always_comb begin
    for (int j = 0; j < DS; j++) begin
      if (j == 0) begin
        rem_nxt[j] = num5_r;
        quo_nxt[j] = '0;
        dd_in[j]   = d5_r;
        cu_in[j]   = cu5_r;
        mix_in[j]  = mix5_r;
      end else begin
        rem_nxt[j] = rem_r[j-1];
        quo_nxt[j] = quo_r[j-1];
        dd_in[j]   = dd_r[j-1];
        cu_in[j]   = cuq_r[j-1];
        mix_in[j]  = mixq_r[j-1];
      end
      for (int b = 0; b < crl_pkg::DIV_STEP; b++) begin
        dsh[j][b] = NW'(dd_in[j]) << (crl_pkg::CH_W - 1 - crl_pkg::DIV_STEP * j - b);
        if (rem_nxt[j] >= dsh[j][b]) begin
          rem_nxt[j] = rem_nxt[j] - dsh[j][b];
          quo_nxt[j][crl_pkg::CH_W - 1 - crl_pkg::DIV_STEP * j - b] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DS; j++) begin
      if (le[crl_pkg::ST_DIV0 + j]) begin
        rem_r[j]  <= rem_nxt[j];
        quo_r[j]  <= quo_nxt[j];
        dd_r[j]   <= dd_in[j];
        cuq_r[j]  <= cu_in[j];
        mixq_r[j] <= mix_in[j];
      end
    end
  end

  assign res = mixq_r[DS-1] ? quo_r[DS-1] : cuq_r[DS-1];

endmodule

[design/color_ramp_lookup.sv]
// Color ramp lookup top level: input stage, flow control, lanes and result port.
// A map result is valid once it has passed the input, search, operand, product, numerator and divide stages.
// Throughput: one item per cycle while no stage is stalled; a load item writes its stop
// from the input stage when that stage advances, and gives no result.
// Stall: each of the 9 stages holds when the one after it is full and stalled.
// Reset clears all stage valid bits and sets stop_count to 4; stops are unset.
module color_ramp_lookup #(
  parameter int MAX_STOPS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_command,
  input  logic [crl_pkg::IDX_PORT_W-1:0] in_stop_index,
  input  logic [crl_pkg::VAL_W-1:0]      in_stop_threshold,
  input  logic [crl_pkg::CH_W-1:0]       in_stop_red,
  input  logic [crl_pkg::CH_W-1:0]       in_stop_green,
  input  logic [crl_pkg::CH_W-1:0]       in_stop_blue,
  input  logic [crl_pkg::CH_W-1:0]       in_stop_alpha,
  input  logic [crl_pkg::VAL_W-1:0]      in_sample_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [crl_pkg::CH_W-1:0]       out_red,
  output logic [crl_pkg::CH_W-1:0]       out_green,
  output logic [crl_pkg::CH_W-1:0]       out_blue,
  output logic [crl_pkg::CH_W-1:0]       out_alpha,
  output logic [crl_pkg::IDX_PORT_W-1:0] out_segment_upper,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [crl_pkg::CNT_W-1:0]      cfg_stop_count
);

  localparam int IW = $clog2(MAX_STOPS);
  localparam int TS = crl_pkg::TAIL_STAGES;
  localparam int CW = crl_pkg::CH_W;

  crl_pkg::stage_en_t le;
  logic [crl_pkg::STAGES:crl_pkg::ST_IN] vld_r;
  logic [crl_pkg::STAGES:crl_pkg::ST_IN] vld_nxt;

  logic [crl_pkg::CNT_W-1:0]      stop_count_r;
  logic [crl_pkg::CNT_EXT_W-1:0]  cnt_ext;
  logic [crl_pkg::CNT_EXT_W-1:0]  n_used;
  logic [IW-1:0]                  n_last;

  crl_pkg::cmd_t                  s1_cmd_r;
  logic [crl_pkg::IDX_PORT_W-1:0] s1_idx_r;
  logic [crl_pkg::VAL_W-1:0]      s1_thr_r;
  logic [crl_pkg::COLOR_W-1:0]    s1_color_r;
  logic [crl_pkg::VAL_W-1:0]      s1_value_r;

  logic [crl_pkg::CNT_EXT_W-1:0]  idx_ext;
  logic                           wr_en;
  logic [IW-1:0]                  wr_addr;

  logic [IW-1:0]                  s3_upper;
  logic                           s3_mix;
  logic [crl_pkg::VAL_W-1:0]      s3_d;
  logic [crl_pkg::VAL_W-1:0]      s3_n;
  logic [crl_pkg::COLOR_W-1:0]    s3_cl;
  logic [crl_pkg::COLOR_W-1:0]    s3_cu;
  logic [crl_pkg::COLOR_W-1:0]    mixed;

  logic [IW-1:0]                  up_r [TS];

  always_comb begin
    le[crl_pkg::STAGES] = !vld_r[crl_pkg::STAGES] || out_ready;
    for (int k = crl_pkg::STAGES - 1; k >= crl_pkg::ST_IN; k--) begin
      le[k] = !vld_r[k] || le[k+1];
    end
  end

  assign in_ready  = le[crl_pkg::ST_IN];
  assign out_valid = vld_r[crl_pkg::STAGES];
  assign cfg_ready = 1'b1;

  always_comb begin
    vld_nxt = vld_r;
    if (le[crl_pkg::ST_IN]) begin
      vld_nxt[crl_pkg::ST_IN] = in_valid;
    end
    if (le[crl_pkg::ST_ENC]) begin
      vld_nxt[crl_pkg::ST_ENC] = vld_r[crl_pkg::ST_IN] && (s1_cmd_r == crl_pkg::CMD_MAP);
    end
    for (int k = crl_pkg::ST_OPND; k <= crl_pkg::STAGES; k++) begin
      if (le[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      stop_count_r <= crl_pkg::STOP_COUNT_RESET;
    end else begin
      vld_r <= vld_nxt;
      if (cfg_valid && cfg_ready) begin
        stop_count_r <= cfg_stop_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (le[crl_pkg::ST_IN]) begin
      s1_cmd_r   <= crl_pkg::cmd_t'(in_command);
      s1_idx_r   <= in_stop_index;
      s1_thr_r   <= in_stop_threshold;
      s1_color_r <= {in_stop_alpha, in_stop_blue, in_stop_green, in_stop_red};
      s1_value_r <= in_sample_value;
    end
  end

  always_comb begin
    cnt_ext = crl_pkg::CNT_EXT_W'(stop_count_r);
    if (cnt_ext < crl_pkg::MIN_STOPS) begin
      n_used = crl_pkg::MIN_STOPS;
    end else if (cnt_ext > crl_pkg::CNT_EXT_W'(MAX_STOPS)) begin
      n_used = crl_pkg::CNT_EXT_W'(MAX_STOPS);
    end else begin
      n_used = cnt_ext;
    end
    n_last = IW'(n_used - crl_pkg::CNT_EXT_W'(1));
  end

  always_comb begin
    idx_ext = crl_pkg::CNT_EXT_W'(s1_idx_r);
    wr_addr = IW'(idx_ext);
    wr_en   = vld_r[crl_pkg::ST_IN] && (s1_cmd_r == crl_pkg::CMD_LOAD)
           && le[crl_pkg::ST_ENC] && (idx_ext < crl_pkg::CNT_EXT_W'(MAX_STOPS));
  end

  crl_stop_table #(
    .MAX_STOPS (MAX_STOPS),
    .IW        (IW)
  ) u_table (
    .clk      (clk),
    .le       (le),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_pos   (s1_thr_r),
    .wr_color (s1_color_r),
    .s1_value (s1_value_r),
    .n_last   (n_last),
    .s3_upper (s3_upper),
    .s3_mix   (s3_mix),
    .s3_d     (s3_d),
    .s3_n     (s3_n),
    .s3_cl    (s3_cl),
    .s3_cu    (s3_cu)
  );

  for (genvar c = 0; c < crl_pkg::NUM_CH; c++) begin : g_lane
    crl_mix_lane u_lane (
      .clk (clk),
      .le  (le),
      .cl  (s3_cl[c*CW +: CW]),
      .cu  (s3_cu[c*CW +: CW]),
      .d   (s3_d),
      .n   (s3_n),
      .mix (s3_mix),
      .res (mixed[c*CW +: CW])
    );
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < TS; k++) begin
      if (le[crl_pkg::ST_PROD + k]) begin
        up_r[k] <= (k == 0) ? s3_upper : up_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign out_red           = mixed[0*CW +: CW];
  assign out_green         = mixed[1*CW +: CW];
  assign out_blue          = mixed[2*CW +: CW];
  assign out_alpha         = mixed[3*CW +: CW];
  assign out_segment_upper = crl_pkg::IDX_PORT_W'(up_r[TS-1]);

endmodule

[test/color_ramp_lookup_check.sv]
// Checker for color_ramp_lookup: tracks the ramp, predicts each mapped color and compares.
module color_ramp_lookup_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_command,
  input  logic [crl_pkg::IDX_PORT_W-1:0] in_stop_index,
  input  logic [crl_pkg::VAL_W-1:0]      in_stop_threshold,
  input  logic [crl_pkg::CH_W-1:0]       in_stop_red,
  input  logic [crl_pkg::CH_W-1:0]       in_stop_green,
  input  logic [crl_pkg::CH_W-1:0]       in_stop_blue,
  input  logic [crl_pkg::CH_W-1:0]       in_stop_alpha,
  input  logic [crl_pkg::VAL_W-1:0]      in_sample_value,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [crl_pkg::CH_W-1:0]       out_red,
  input  logic [crl_pkg::CH_W-1:0]       out_green,
  input  logic [crl_pkg::CH_W-1:0]       out_blue,
  input  logic [crl_pkg::CH_W-1:0]       out_alpha,
  input  logic [crl_pkg::IDX_PORT_W-1:0] out_segment_upper,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [crl_pkg::CNT_W-1:0]      cfg_stop_count,
  output int                             mismatches,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import crl_pkg::*;

  localparam int RAMP_DEPTH = 8;

  typedef struct packed {
    logic [NUM_CH-1:0][CH_W-1:0] rgba;
    logic [IDX_PORT_W-1:0]       upper;
  } shade_t;

  logic [VAL_W-1:0] ramp_pos [RAMP_DEPTH] = '{default: '0};
  logic [CH_W-1:0]  ramp_rgba [RAMP_DEPTH][NUM_CH] = '{default: '{default: '0}};
  logic [CNT_W-1:0] ramp_used = STOP_COUNT_RESET;
  shade_t           shade_due [$];
  shade_t           seen;
  shade_t           want;
  int               fails = 0;

  function automatic shade_t blend(input logic [VAL_W-1:0] v);
    int unsigned used;
    int unsigned hi;
    int unsigned d;
    int unsigned n;
    int unsigned num;
    int          ch;
    shade_t      s;
    used = 32'(ramp_used);
    if (used < 32'(MIN_STOPS)) used = 32'(MIN_STOPS);
    if (used > RAMP_DEPTH) used = RAMP_DEPTH;
    hi = 0;
    while (hi < used - 1 && v >= ramp_pos[hi]) hi++;
    for (ch = 0; ch < NUM_CH; ch++) begin
      s.rgba[ch] = ramp_rgba[hi][ch];
      if (hi != 0 && ramp_pos[hi] > ramp_pos[hi-1] && v < ramp_pos[hi]) begin
        d   = 32'(ramp_pos[hi]) - 32'(ramp_pos[hi-1]);
        n   = 32'(v) - 32'(ramp_pos[hi-1]);
        num = 32'(ramp_rgba[hi-1][ch]) * (d - n) + 32'(ramp_rgba[hi][ch]) * n + d / 2;
        s.rgba[ch] = CH_W'(num / d);
      end
    end
    s.upper = IDX_PORT_W'(hi);
    return s;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ramp_used = STOP_COUNT_RESET;
      shade_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen.rgba  = {out_alpha, out_blue, out_green, out_red};
        seen.upper = out_segment_upper;
        if (shade_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected transfer r=%0d g=%0d b=%0d a=%0d seg=%0d", $time,
                     out_red, out_green, out_blue, out_alpha, out_segment_upper);
        end else begin
          want = shade_due.pop_front();
          if (seen !== want) begin
            fails++;
            if (fails <= 10)
              $display({"%0t: mismatch expected r=%0d g=%0d b=%0d a=%0d seg=%0d,",
                        " got r=%0d g=%0d b=%0d a=%0d seg=%0d"}, $time,
                       want.rgba[0], want.rgba[1], want.rgba[2], want.rgba[3], want.upper,
                       seen.rgba[0], seen.rgba[1], seen.rgba[2], seen.rgba[3], seen.upper);
          end
        end
      end
      if (cfg_valid && cfg_ready) ramp_used = cfg_stop_count;
      if (in_valid && in_ready) begin
        if (cmd_t'(in_command) == CMD_LOAD) begin
          ramp_pos[in_stop_index]     = in_stop_threshold;
          ramp_rgba[in_stop_index][0] = in_stop_red;
          ramp_rgba[in_stop_index][1] = in_stop_green;
          ramp_rgba[in_stop_index][2] = in_stop_blue;
          ramp_rgba[in_stop_index][3] = in_stop_alpha;
        end else begin
          shade_due = {shade_due, blend(in_sample_value)};
        end
      end
    end
    mismatches <= fails;
    pending    <= shade_due.size();
  end

endmodule

[test/color_ramp_lookup_test.sv]
// Testbench top for color_ramp_lookup: clock, reset, stimulus, output pacing and verdict.
module color_ramp_lookup_test;
  timeunit 1ns;
  timeprecision 1ps;
  import crl_pkg::*;

  localparam int RAMP_DEPTH   = 8;
  localparam int RANDOM_ITEMS = 430;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 200;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    cmd_t                        cmd;
    logic [IDX_PORT_W-1:0]       idx;
    logic [VAL_W-1:0]            th;
    logic [NUM_CH-1:0][CH_W-1:0] rgba;
    logic [VAL_W-1:0]            value;
  } job_t;

  logic                  clk               = 1'b0;
  logic                  rst_n             = 1'b0;
  logic                  in_valid          = 1'b0;
  logic                  in_ready;
  logic                  in_command        = 1'b0;
  logic [IDX_PORT_W-1:0] in_stop_index     = '0;
  logic [VAL_W-1:0]      in_stop_threshold = '0;
  logic [CH_W-1:0]       in_stop_red       = '0;
  logic [CH_W-1:0]       in_stop_green     = '0;
  logic [CH_W-1:0]       in_stop_blue      = '0;
  logic [CH_W-1:0]       in_stop_alpha     = '0;
  logic [VAL_W-1:0]      in_sample_value   = '0;
  logic                  out_valid;
  logic                  out_ready         = 1'b0;
  logic [CH_W-1:0]       out_red;
  logic [CH_W-1:0]       out_green;
  logic [CH_W-1:0]       out_blue;
  logic [CH_W-1:0]       out_alpha;
  logic [IDX_PORT_W-1:0] out_segment_upper;
  logic                  cfg_valid         = 1'b0;
  logic                  cfg_ready;
  logic [CNT_W-1:0]      cfg_stop_count    = '0;

  int               mismatches;
  int               pending;
  bit               pace_input = 1'b1;
  bit               hold_off   = 1'b0;
  logic [VAL_W-1:0] ramp_th [RAMP_DEPTH] = '{default: '0};

  always #5ns clk = ~clk;

  color_ramp_lookup i_dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_command, .in_stop_index, .in_stop_threshold,
    .in_stop_red, .in_stop_green, .in_stop_blue, .in_stop_alpha, .in_sample_value,
    .out_valid, .out_ready, .out_red, .out_green, .out_blue, .out_alpha, .out_segment_upper,
    .cfg_valid, .cfg_ready, .cfg_stop_count
  );

  color_ramp_lookup_check i_check (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_command, .in_stop_index, .in_stop_threshold,
    .in_stop_red, .in_stop_green, .in_stop_blue, .in_stop_alpha, .in_sample_value,
    .out_valid, .out_ready, .out_red, .out_green, .out_blue, .out_alpha, .out_segment_upper,
    .cfg_valid, .cfg_ready, .cfg_stop_count,
    .mismatches, .pending
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic job_t load_job(input int idx, input logic [VAL_W-1:0] th,
                                    input logic [COLOR_W-1:0] rgba);
    job_t j;
    j.cmd   = CMD_LOAD;
    j.idx   = IDX_PORT_W'(idx);
    j.th    = th;
    j.rgba  = rgba;
    j.value = VAL_W'($urandom);
    return j;
  endfunction

  function automatic job_t map_job(input logic [VAL_W-1:0] v);
    job_t j;
    j.cmd   = CMD_MAP;
    j.idx   = IDX_PORT_W'($urandom);
    j.th    = VAL_W'($urandom);
    j.rgba  = $urandom;
    j.value = v;
    return j;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    int t;
    r = $urandom_range(0, 99);
    if (r < 45) return VAL_W'($urandom);
    if (r < 85) begin
      t = int'(ramp_th[$urandom_range(0, RAMP_DEPTH-1)]) + int'($urandom_range(0, 6)) - 3;
      return VAL_W'(t);
    end
    if (r < 92) return '0;
    return '1;
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    if ($urandom_range(0, 99) < 75) return CNT_W'($urandom_range(2, RAMP_DEPTH));
    return CNT_W'($urandom_range(0, 15));
  endfunction

  task automatic put_item(input job_t j);
    int g;
    g = pace_input ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= j.cmd;
    in_stop_index     <= j.idx;
    in_stop_threshold <= j.th;
    in_stop_red       <= j.rgba[0];
    in_stop_green     <= j.rgba[1];
    in_stop_blue      <= j.rgba[2];
    in_stop_alpha     <= j.rgba[3];
    in_sample_value   <= j.value;
    do @(posedge clk); while (!in_ready);
    if (j.cmd == CMD_LOAD) ramp_th[j.idx] = j.th;
  endtask

  task automatic load_ramp(input bit ordered);
    logic [VAL_W-1:0] th [RAMP_DEPTH];
    logic [VAL_W-1:0] t;
    logic [VAL_W-1:0] base;
    int               i;
    int               k;
    bit               narrow;
    narrow = $urandom_range(0, 99) < 30;
    base   = VAL_W'($urandom);
    for (i = 0; i < RAMP_DEPTH; i++)
      th[i] = narrow ? base + VAL_W'($urandom_range(0, 255)) : VAL_W'($urandom);
    if (ordered) begin
      for (i = 1; i < RAMP_DEPTH; i++) begin
        t = th[i];
        k = i - 1;
        while (k >= 0 && th[k] > t) begin
          th[k+1] = th[k];
          k--;
        end
        th[k+1] = t;
      end
    end else if ($urandom_range(0, 1) == 1) begin
      k = $urandom_range(1, RAMP_DEPTH-1);
      th[k] = th[k-1];
    end
    for (i = 0; i < RAMP_DEPTH; i++) put_item(load_job(i, th[i], $urandom));
  endtask

  task automatic set_stop_count(input logic [CNT_W-1:0] count);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_stop_count <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int  g;
    bit  held;
    held = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("** color_ramp_lookup: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int next_cfg;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // ramp with equal, descending and zero thresholds
    put_item(load_job(0, 16'h1000, 32'hFF00FF00));
    put_item(load_job(1, 16'h3000, 32'h00FF00FF));
    put_item(load_job(2, 16'h3000, 32'h80402010));
    put_item(load_job(3, 16'h8000, 32'hFFFFFFFF));
    put_item(load_job(4, 16'h7000, 32'h00000000));
    put_item(load_job(5, 16'hA000, 32'h12345678));
    put_item(load_job(6, 16'hFFFF, 32'hFEDCBA98));
    put_item(load_job(7, 16'h0000, 32'h55AA55AA));
    put_item(map_job(16'h0000));
    put_item(map_job(16'h0FFF));
    put_item(map_job(16'h1000));
    put_item(map_job(16'h2000));
    put_item(map_job(16'h3000));
    put_item(map_job(16'hFFFF));
    set_stop_count(4'd8);
    put_item(map_job(16'h7800));
    put_item(map_job(16'h8000));
    put_item(map_job(16'hFFFE));
    put_item(map_job(16'hFFFF));
    set_stop_count(4'd2);
    put_item(map_job(16'hFFFF));
    set_stop_count(4'd0);
    put_item(map_job(16'h2000));
    set_stop_count(4'd1);
    put_item(map_job(16'h0800));
    set_stop_count(4'd15);
    put_item(map_job(16'h9000));
    set_stop_count(4'd9);
    put_item(map_job(16'hC000));

    sent       = 0;
    next_cfg   = 90;
    pace_input = 1'b0;
    hold_off   = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_cfg) begin
        set_stop_count(pick_count());
        next_cfg += 90;
      end
      if ($urandom_range(0, 99) < 25) begin
        load_ramp($urandom_range(0, 99) < 75);
        sent += RAMP_DEPTH;
      end
      repeat ($urandom_range(20, 50)) begin
        if ($urandom_range(0, 99) < 12)
          put_item(load_job($urandom_range(0, RAMP_DEPTH-1), VAL_W'($urandom), $urandom));
        else
          put_item(map_job(pick_value()));
        sent++;
      end
      pace_input = $urandom_range(0, 3) != 0;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("** color_ramp_lookup: PASSED **");
    else
      $display("** color_ramp_lookup: FAILED **");
    $finish;
  end

endmodule
